// ----- hw/rtl/lprc_pkg.sv -----
`timescale 1ns / 1ps

package lprc_pkg;

  localparam int unsigned CNT_W = 24;

  localparam logic [CNT_W-1:0] HOLD_TICKS_RST      = CNT_W'(5000);
  localparam logic [CNT_W-1:0] COUNTDOWN_TICKS_RST = CNT_W'(10000);

  typedef enum logic [2:0] {
    MODE_ALLOWED    = 3'd0,
    MODE_DISALLOWED = 3'd1,
    MODE_HOLD       = 3'd2,
    MODE_COUNTDOWN  = 3'd3,
    MODE_TRIGGERED  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ACT_BUTTON = 2'd0,
    ACT_POLICY = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Register indexes on the configuration port.
  localparam logic REG_HOLD      = 1'b0;
  localparam logic REG_COUNTDOWN = 1'b1;

  typedef struct packed {
    mode_t            mode;
    logic [CNT_W-1:0] cnt;
    logic             consumed;
    logic             notify;
    logic             trigger;
  } step_t;

endpackage

// ----- hw/rtl/lprc_core.sv -----
`timescale 1ns / 1ps

module lprc_core import lprc_pkg::*; (
  input  action_t          action,
  input  logic             button_pressed,
  input  logic             reset_allowed,
  input  mode_t            mode_r,
  input  logic [CNT_W-1:0] cnt_r,
  input  logic [CNT_W-1:0] hold_ticks,
  input  logic [CNT_W-1:0] countdown_ticks,
  output step_t            step
);

  mode_t mode_nxt;
  logic  expired;

  // A timer loaded with zero or one runs out on the next tick.
  assign expired = (cnt_r <= CNT_W'(1));

  always_comb begin
    mode_nxt = mode_r;
    unique case (action)
      ACT_BUTTON: begin
        unique case (mode_r)
          MODE_ALLOWED:   if (button_pressed) mode_nxt = MODE_HOLD;
          MODE_HOLD,
          MODE_COUNTDOWN: if (!button_pressed) mode_nxt = MODE_ALLOWED;
          default: ;
        endcase
      end
      ACT_POLICY: begin
        if (!reset_allowed) begin
          mode_nxt = MODE_DISALLOWED;
        end else if (mode_r == MODE_DISALLOWED) begin
          mode_nxt = MODE_ALLOWED;
        end
      end
      ACT_TICK: begin
        if (mode_r == MODE_HOLD && expired) begin
          mode_nxt = MODE_COUNTDOWN;
        end else if (mode_r == MODE_COUNTDOWN && expired) begin
          mode_nxt = MODE_TRIGGERED;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    step          = '0;
    step.mode     = mode_nxt;
    step.cnt      = cnt_r;
    unique case (action)
      ACT_BUTTON: begin
        unique case (mode_r)
          MODE_ALLOWED: begin
            step.consumed = button_pressed;
            if (button_pressed) step.cnt = hold_ticks;
          end
          MODE_DISALLOWED: step.consumed = button_pressed;
          MODE_HOLD: begin
            step.consumed = 1'b1;
            if (!button_pressed) step.cnt = '0;
          end
          MODE_COUNTDOWN: begin
            step.consumed = 1'b1;
            if (!button_pressed) begin
              step.cnt    = '0;
              step.notify = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ACT_POLICY: begin
        if (!reset_allowed) begin
          step.cnt    = '0;
          step.notify = (mode_r == MODE_COUNTDOWN);
        end
      end
      ACT_TICK: begin
        if (mode_r == MODE_HOLD || mode_r == MODE_COUNTDOWN) begin
          if (!expired) begin
            step.cnt = cnt_r - CNT_W'(1);
          end else if (mode_r == MODE_HOLD) begin
            step.cnt    = countdown_ticks;
            step.notify = 1'b1;
          end else begin
            step.cnt     = '0;
            step.trigger = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/long_press_reset_controller.sv -----
`timescale 1ns / 1ps

// Long-press factory reset guard. Each input word is a button report, a
// reset policy change or one timer tick, selected by in_tuser; each one
// yields exactly one result word. The block takes one word per cycle: the
// mode and tick counter are computed combinationally from their registered
// values and the result sits in an output register, so a new word is taken
// whenever that register is empty or read in the same cycle. The user must
// set the hold and countdown lengths on the configuration port (hold_ticks
// at address 0, countdown_ticks at address 4) only while idle; not enforced.
module long_press_reset_controller import lprc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] button_pressed, [1] reset_allowed, [7:2] zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] consumed, [3:1] mode, [27:4] remaining_ticks, [28] notify_watchers,
  // [29] reset_pulse, [31:30] zero
  output logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [CNT_W-1:0] hold_ticks_r;
  logic [CNT_W-1:0] countdown_ticks_r;
  mode_t            mode_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  logic [31:0]      out_data_r;
  logic [31:0]      out_data_nxt;
  logic             in_acc;
  logic             cfg_wr;
  logic [CNT_W-1:0] remaining;
  step_t            step;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r      <= HOLD_TICKS_RST;
      countdown_ticks_r <= COUNTDOWN_TICKS_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_HOLD) begin
        hold_ticks_r <= cfg_pwdata[CNT_W-1:0];
      end else begin
        countdown_ticks_r <= cfg_pwdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_COUNTDOWN) begin
      cfg_prdata = {{(32-CNT_W){1'b0}}, countdown_ticks_r};
    end else begin
      cfg_prdata = {{(32-CNT_W){1'b0}}, hold_ticks_r};
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  lprc_core u_core (
    .action          (action_t'(in_tuser)),
    .button_pressed  (in_tdata[0]),
    .reset_allowed   (in_tdata[1]),
    .mode_r          (mode_r),
    .cnt_r           (cnt_r),
    .hold_ticks      (hold_ticks_r),
    .countdown_ticks (countdown_ticks_r),
    .step            (step)
  );

  assign remaining    = (step.mode == MODE_COUNTDOWN) ? step.cnt : '0;
  assign out_data_nxt = {2'b00, step.trigger, step.notify, remaining, step.mode,
                         step.consumed};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_ALLOWED;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_r      <= step.mode;
        cnt_r       <= step.cnt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_trigger_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[29] |-> out_tdata[3:1] == MODE_TRIGGERED)
    else $error("trigger reported outside triggered mode");

  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_HOLD && mode_r != MODE_COUNTDOWN |-> cnt_r == '0)
    else $error("tick counter not cleared outside a timer");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !in_acc |=> $stable(mode_r) && $stable(cnt_r))
    else $error("state changed without an accepted word");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("accepted word produced no result");

endmodule
